@@ hw/rtl/mdew_pkg.sv @@
// shared types, constants and neighbour calculation for the dead-end marking walker
package mdew_pkg;

  // map geometry
  localparam int MAP_WIDTH  = 32;
  localparam int MAP_HEIGHT = 32;
  localparam int GRID_BITS  = 5;
  localparam int GRID       = 1 << GRID_BITS;
  localparam int ADDR_W     = 2 * GRID_BITS;
  localparam int MAP_CELLS  = 1 << ADDR_W;
  localparam int LIM_X      = (MAP_WIDTH < GRID) ? MAP_WIDTH : GRID;
  localparam int LIM_Y      = (MAP_HEIGHT < GRID) ? MAP_HEIGHT : GRID;

  localparam int TILE_W     = 4;
  localparam int CNT_W      = 3;
  localparam int CFG_AW     = 4;
  localparam int CFG_DW     = 32;

  typedef logic [GRID_BITS-1:0] coord_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [TILE_W-1:0]    tile_t;

  // register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_START_X   = 2'd0,
    REG_START_Y   = 2'd1,
    REG_GOAL_CODE = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_RESTART = 2'd1,
    OP_STEP    = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_LAST = 2'd2,
    ST_DONE = 2'd3
  } state_t;

  // requests from the sequencer to the map memories
  typedef struct packed {
    addr_t tile_addr;
    addr_t open_addr;
    logic  load_en;
    addr_t load_addr;
    tile_t load_tile;
    logic  close_en;
    addr_t close_addr;
  } map_req_t;

  // neighbour of a cell: whether it lies on the grid, and its coordinates
  // clamped to the coordinate range
  typedef struct packed {
    logic   in_grid;
    coord_t x;
    coord_t y;
  } nbr_t;

  function automatic nbr_t nbr_calc(dir_t d, coord_t x, coord_t y);
    logic [GRID_BITS+1:0] nx;
    logic [GRID_BITS+1:0] ny;
    nbr_t r;
    nx = {2'b00, x};
    ny = {2'b00, y};
    unique case (d)
      DIR_UP:    ny = ny - 1'b1;
      DIR_DOWN:  ny = ny + 1'b1;
      DIR_LEFT:  nx = nx - 1'b1;
      DIR_RIGHT: nx = nx + 1'b1;
      default:   nx = nx;
    endcase
    r.in_grid = !nx[GRID_BITS+1] && !ny[GRID_BITS+1] &&
                (nx < (GRID_BITS+2)'(LIM_X)) && (ny < (GRID_BITS+2)'(LIM_Y));
    r.x = (nx[GRID_BITS+1:GRID_BITS] == 2'b00) ? nx[GRID_BITS-1:0] : x;
    r.y = (ny[GRID_BITS+1:GRID_BITS] == 2'b00) ? ny[GRID_BITS-1:0] : y;
    return r;
  endfunction

  function automatic logic cell_in_grid(coord_t x, coord_t y);
    return ({1'b0, x} < (GRID_BITS+1)'(LIM_X)) && ({1'b0, y} < (GRID_BITS+1)'(LIM_Y));
  endfunction

  function automatic addr_t cell_addr(coord_t x, coord_t y);
    return {y, x};
  endfunction

endpackage

@@ hw/rtl/maze_dead_end_marking_walker.sv @@
// A step reads the four neighbours in state ST_READ: the reads share the single
// open-map read port, one per cycle, the last registered read data arrives in
// ST_LAST, and the move is evaluated in ST_DONE. Load, restart and no-op items go
// straight to ST_DONE. A new item is taken only in ST_IDLE; a result that waits
// on out_ready holds the next item in ST_DONE until the waiting result is taken.
// Reset (rst_n low, synchronous): walker at (1,0), marking on, came-from left,
// goal flag clear, registers at their defaults; map contents stay undefined.
module maze_dead_end_marking_walker (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_opcode,
  input  logic [4:0]                    in_cell_x,
  input  logic [4:0]                    in_cell_y,
  input  logic [3:0]                    in_tile_value,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [4:0]                    out_pos_x,
  output logic [4:0]                    out_pos_y,
  output logic [1:0]                    out_moved_dir,
  output logic                          out_retreated,
  output logic                          out_goal_reached,
  output logic [2:0]                    out_open_count,
  // configuration port
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [mdew_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [mdew_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [mdew_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  // configuration registers
  mdew_pkg::coord_t   start_x_r;
  mdew_pkg::coord_t   start_y_r;
  mdew_pkg::tile_t    goal_code_r;
  mdew_pkg::reg_idx_t cfg_idx;
  logic               cfg_wr;

  // sequencer and walker state
  mdew_pkg::state_t   state_r, state_nxt;
  mdew_pkg::dir_t     rd_dir_r, rd_dir_nxt;
  mdew_pkg::op_t      op_r;
  mdew_pkg::coord_t   cx_r;
  mdew_pkg::coord_t   cy_r;
  mdew_pkg::tile_t    tv_r;
  mdew_pkg::coord_t   walk_x_r, walk_x_nxt;
  mdew_pkg::coord_t   walk_y_r, walk_y_nxt;
  logic               marking_r, marking_nxt;
  mdew_pkg::dir_t     came_r, came_nxt;
  logic               goal_seen_r, goal_seen_nxt;

  // read pipeline bookkeeping
  logic               pend_vld_r;
  mdew_pkg::dir_t     pend_dir_r;
  logic               pend_in_r;
  logic [3:0]         open_bits_r;
  logic               goal_hit_r;

  // output register
  logic               out_valid_r;
  mdew_pkg::coord_t   out_x_r;
  mdew_pkg::coord_t   out_y_r;
  mdew_pkg::dir_t     out_dir_r;
  logic               out_back_r;
  logic               out_goal_r;
  logic [mdew_pkg::CNT_W-1:0] out_cnt_r;

  // combinational evaluation
  mdew_pkg::map_req_t req;
  mdew_pkg::tile_t    tile_q;
  logic               open_q;
  mdew_pkg::dir_t     nbr_dir;
  mdew_pkg::nbr_t     nbr;
  logic               in_acc;
  logic               commit;
  logic               cur_in;
  logic [mdew_pkg::CNT_W-1:0] cnt;
  logic               mark_keep;
  logic               found;
  mdew_pkg::dir_t     mv_dir;
  mdew_pkg::dir_t     res_dir;
  logic               res_back;
  logic [mdew_pkg::CNT_W-1:0] res_cnt;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_idx    = mdew_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r   <= mdew_pkg::coord_t'(1);
      start_y_r   <= '0;
      goal_code_r <= mdew_pkg::tile_t'(3);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        mdew_pkg::REG_START_X:   start_x_r   <= cfg_pwdata[4:0];
        mdew_pkg::REG_START_Y:   start_y_r   <= cfg_pwdata[4:0];
        mdew_pkg::REG_GOAL_CODE: goal_code_r <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      mdew_pkg::REG_START_X:   cfg_prdata = {{(mdew_pkg::CFG_DW-5){1'b0}}, start_x_r};
      mdew_pkg::REG_START_Y:   cfg_prdata = {{(mdew_pkg::CFG_DW-5){1'b0}}, start_y_r};
      mdew_pkg::REG_GOAL_CODE: cfg_prdata = {{(mdew_pkg::CFG_DW-4){1'b0}}, goal_code_r};
      default:                 cfg_prdata = '0;
    endcase
  end

  // handshakes
  assign in_ready = (state_r == mdew_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign commit   = (state_r == mdew_pkg::ST_DONE) && (!out_valid_r || out_ready);

  // shared neighbour unit: the read direction while reading, the chosen move after
  assign nbr_dir = (state_r == mdew_pkg::ST_READ) ? rd_dir_r : res_dir;
  assign nbr     = mdew_pkg::nbr_calc(nbr_dir, walk_x_r, walk_y_r);
  assign cur_in  = mdew_pkg::cell_in_grid(walk_x_r, walk_y_r);

  // step decision from the collected neighbour bits
  always_comb begin
    cnt = mdew_pkg::CNT_W'(open_bits_r[0]) + mdew_pkg::CNT_W'(open_bits_r[1]) +
          mdew_pkg::CNT_W'(open_bits_r[2]) + mdew_pkg::CNT_W'(open_bits_r[3]);
    mark_keep = marking_r && (cnt <= mdew_pkg::CNT_W'(1));
    found  = 1'b0;
    mv_dir = mdew_pkg::DIR_UP;
    for (int d = 0; d < 4; d++) begin
      if (!found && (mdew_pkg::dir_t'(d) != came_r) && open_bits_r[d]) begin
        found  = 1'b1;
        mv_dir = mdew_pkg::dir_t'(d);
      end
    end
    res_dir = found ? mv_dir : came_r;
  end

  // next state, map requests and results
  always_comb begin
    state_nxt     = state_r;
    rd_dir_nxt    = rd_dir_r;
    walk_x_nxt    = walk_x_r;
    walk_y_nxt    = walk_y_r;
    marking_nxt   = marking_r;
    came_nxt      = came_r;
    goal_seen_nxt = goal_seen_r;
    res_back      = 1'b0;
    res_cnt       = '0;

    req.tile_addr  = mdew_pkg::cell_addr(walk_x_r, walk_y_r);
    req.open_addr  = mdew_pkg::cell_addr(nbr.x, nbr.y);
    req.load_en    = 1'b0;
    req.load_addr  = mdew_pkg::cell_addr(cx_r, cy_r);
    req.load_tile  = tv_r;
    req.close_en   = 1'b0;
    req.close_addr = mdew_pkg::cell_addr(walk_x_r, walk_y_r);

    unique case (state_r)
      mdew_pkg::ST_IDLE: begin
        rd_dir_nxt = mdew_pkg::DIR_UP;
        if (in_acc) begin
          state_nxt = (mdew_pkg::op_t'(in_opcode) == mdew_pkg::OP_STEP) ?
                      mdew_pkg::ST_READ : mdew_pkg::ST_DONE;
        end
      end
      mdew_pkg::ST_READ: begin
        if (rd_dir_r == mdew_pkg::DIR_RIGHT) begin
          state_nxt = mdew_pkg::ST_LAST;
        end else begin
          rd_dir_nxt = mdew_pkg::dir_t'(rd_dir_r + 2'd1);
        end
      end
      mdew_pkg::ST_LAST: begin
        state_nxt = mdew_pkg::ST_DONE;
      end
      mdew_pkg::ST_DONE: begin
        if (commit) begin
          state_nxt = mdew_pkg::ST_IDLE;
          unique case (op_r)
            mdew_pkg::OP_LOAD: begin
              req.load_en = mdew_pkg::cell_in_grid(cx_r, cy_r);
            end
            mdew_pkg::OP_RESTART: begin
              walk_x_nxt  = start_x_r;
              walk_y_nxt  = start_y_r;
              marking_nxt = 1'b1;
              came_nxt    = mdew_pkg::DIR_LEFT;
            end
            mdew_pkg::OP_STEP: begin
              goal_seen_nxt = goal_seen_r || goal_hit_r;
              res_cnt       = cnt;
              walk_x_nxt    = nbr.x;
              walk_y_nxt    = nbr.y;
              came_nxt      = mdew_pkg::dir_t'(res_dir ^ 2'd1);
              if (found) begin
                marking_nxt  = mark_keep;
                req.close_en = mark_keep && cur_in;
              end else begin
                marking_nxt  = 1'b1;
                req.close_en = cur_in;
                res_back     = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      default: state_nxt = mdew_pkg::ST_IDLE;
    endcase
  end

  mdew_map u_map (
    .clk    (clk),
    .req    (req),
    .tile_q (tile_q),
    .open_q (open_q)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mdew_pkg::ST_IDLE;
      rd_dir_r    <= mdew_pkg::DIR_UP;
      walk_x_r    <= mdew_pkg::coord_t'(1);
      walk_y_r    <= '0;
      marking_r   <= 1'b1;
      came_r      <= mdew_pkg::DIR_LEFT;
      goal_seen_r <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_dir_r    <= rd_dir_nxt;
      walk_x_r    <= walk_x_nxt;
      walk_y_r    <= walk_y_nxt;
      marking_r   <= marking_nxt;
      came_r      <= came_nxt;
      goal_seen_r <= goal_seen_nxt;
      pend_vld_r  <= (state_r == mdew_pkg::ST_READ);
      out_valid_r <= commit || (out_valid_r && !out_ready);
    end
  end

  // accepted transaction fields
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r <= mdew_pkg::op_t'(in_opcode);
      cx_r <= in_cell_x;
      cy_r <= in_cell_y;
      tv_r <= in_tile_value;
    end
  end

  // collect each neighbour read in the cycle after it is issued
  always_ff @(posedge clk) begin
    pend_dir_r <= rd_dir_r;
    pend_in_r  <= nbr.in_grid;
    if (pend_vld_r) begin
      open_bits_r[pend_dir_r] <= pend_in_r && open_q;
      if (pend_dir_r == mdew_pkg::DIR_UP) begin
        goal_hit_r <= cur_in && (tile_q == goal_code_r);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (commit) begin
      out_x_r    <= walk_x_nxt;
      out_y_r    <= walk_y_nxt;
      out_dir_r  <= (op_r == mdew_pkg::OP_STEP) ? res_dir : mdew_pkg::DIR_UP;
      out_back_r <= res_back;
      out_goal_r <= goal_seen_nxt;
      out_cnt_r  <= res_cnt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pos_x        = out_x_r;
  assign out_pos_y        = out_y_r;
  assign out_moved_dir    = out_dir_r;
  assign out_retreated    = out_back_r;
  assign out_goal_reached = out_goal_r;
  assign out_open_count   = out_cnt_r;

endmodule

@@ hw/rtl/mdew_map.sv @@
// tile map and open map memories with registered read data
module mdew_map (
  input  logic               clk,
  input  mdew_pkg::map_req_t req,
  output mdew_pkg::tile_t    tile_q,
  output logic               open_q
);

  mdew_pkg::tile_t tile_mem [mdew_pkg::MAP_CELLS];
  logic            open_mem [mdew_pkg::MAP_CELLS];

  // tile codes change only on load
  always_ff @(posedge clk) begin
    if (req.load_en) begin
      tile_mem[req.load_addr] <= req.load_tile;
    end
    tile_q <= tile_mem[req.tile_addr];
  end

  // open bits: written on load (open for a nonzero tile), cleared when the walker marks a cell
  always_ff @(posedge clk) begin
    if (req.load_en) begin
      open_mem[req.load_addr] <= (req.load_tile != '0);
    end else if (req.close_en) begin
      open_mem[req.close_addr] <= 1'b0;
    end
    open_q <= open_mem[req.open_addr];
  end

endmodule

@@ hw/rtl/mdew_checker.sv @@
// port-level checks for the dead-end marking walker, bound to the top level
module mdew_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] out_pos_x,
  input logic [4:0] out_pos_y,
  input logic       out_retreated,
  input logic [2:0] out_open_count,
  input logic       cfg_pready
);

  // the configuration port never stalls
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("cfg_pready low");

  // one transaction at a time: ready drops after an accepted item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // a retreat means no exit besides the came-from side
  a_retreat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_retreated |-> out_open_count <= 3'd1)
    else $error("retreat with several open neighbours");

  // at most four neighbours
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_open_count <= 3'd4)
    else $error("open count out of range");

  // a stalled result holds its position
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pos_x) && $stable(out_pos_y))
    else $error("stalled result changed");

endmodule

bind maze_dead_end_marking_walker mdew_checker u_mdew_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_pos_x      (out_pos_x),
  .out_pos_y      (out_pos_y),
  .out_retreated  (out_retreated),
  .out_open_count (out_open_count),
  .cfg_pready     (cfg_pready)
);
